>>> rtl/core/packet_flow_counter_assert.svh
// Assertion macros for the packet flow counter checker.
// Plain text macros only; no other dependencies.
`ifndef PACKET_FLOW_COUNTER_ASSERT_SVH
`define PACKET_FLOW_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pfc_pkg.sv
// Package for the packet flow counter: types, constants and helper functions.
// No dependencies; the interfaces, top level, checker and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

   localparam int FLOW_ENTRIES_DEFAULT = 256;

   localparam int PROTO_W   = 8;
   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int LEN_W     = 16;
   localparam int COUNT_W   = 32;
   localparam int FLOWS_W   = 9;
   localparam int ALL_FLOWS_W = 10;

   localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

   typedef struct packed {
      logic [ADDR_W-1:0] src;
      logic [ADDR_W-1:0] dst;
      logic [PORT_W-1:0] sport;
      logic [PORT_W-1:0] dport;
   } flow_key_type;

   localparam int KEY_W = $bits(flow_key_type);

   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_TCP,
      CLS_UDP
   } flow_class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // Adds and holds at all ones on overflow.
   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/pfc_if.sv
// Channel interfaces of the packet flow counter: header words in, count words out.
// Depends on pfc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfc_req_if import pfc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PROTO_W-1:0] protocol;
   logic [ADDR_W-1:0]  source_address;
   logic [ADDR_W-1:0]  destination_address;
   logic [PORT_W-1:0]  source_port;
   logic [PORT_W-1:0]  destination_port;
   logic [LEN_W-1:0]   packet_length;

   modport source (output valid, protocol, source_address, destination_address,
                   source_port, destination_port, packet_length, input ready);
   modport sink (input valid, protocol, source_address, destination_address,
                 source_port, destination_port, packet_length, output ready);
endinterface

interface pfc_rsp_if import pfc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_W-1:0]     total_packets;
   logic [COUNT_W-1:0]     tcp_packets;
   logic [COUNT_W-1:0]     udp_packets;
   logic [COUNT_W-1:0]     tcp_byte_total;
   logic [COUNT_W-1:0]     udp_byte_total;
   logic [FLOWS_W-1:0]     tcp_flow_count;
   logic [FLOWS_W-1:0]     udp_flow_count;
   logic [ALL_FLOWS_W-1:0] all_flow_count;
   logic                   new_flow;
   logic                   table_full;

   modport source (output valid, total_packets, tcp_packets, udp_packets,
                   tcp_byte_total, udp_byte_total, tcp_flow_count, udp_flow_count,
                   all_flow_count, new_flow, table_full, input ready);
   modport sink (input valid, total_packets, tcp_packets, udp_packets,
                 tcp_byte_total, udp_byte_total, tcp_flow_count, udp_flow_count,
                 all_flow_count, new_flow, table_full, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pfc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfc_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/packet_flow_counter.sv
// Top level of the packet flow counter: packet and byte counters, flow tables.
// Depends on pfc_pkg, the channel interfaces in pfc_if and the RAM in pfc_ram.
//
//   channel | direction | word                                  | handshake
//   --------+-----------+---------------------------------------+----------------
//   req_if  | in        | protocol, tuple, packet_length        | valid / ready
//   rsp_if  | out       | counters, flow counts, new/full flags | valid / ready
//
// A header word is taken only in the idle state; one word is in work at a time.
// A TCP or UDP word whose table holds tuples is searched from the first entry
// up, ending early on a hit; any other protocol or an empty table goes
// straight to the finish state. The search rate is set by the single read port
// of the flow RAM, which yields one stored tuple per cycle.
// Reset (synchronous) clears the counters and fill counts; the RAMs need no
// clearing, as only entries below the fill count are ever read.
// The result sits in an output register, so a new word is accepted while the
// previous result is still waiting; a finished search only stalls if that
// register is still full.

`timescale 1ns / 1ps
`default_nettype none

module packet_flow_counter import pfc_pkg::*; #(
   parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   pfc_req_if.sink   req_if,
   pfc_rsp_if.source rsp_if
);

   // Index width into a table and width of a fill count that can reach the depth.
   localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
   localparam int EXT_W = CNT_W + ALL_FLOWS_W;
   localparam logic [CNT_W-1:0] TABLE_DEPTH = CNT_W'(FLOW_ENTRIES);

   // Control state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   tcp_used_ff, tcp_used_in;
   logic [CNT_W-1:0]   udp_used_ff, udp_used_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] tcp_pkts_ff, tcp_pkts_in;
   logic [COUNT_W-1:0] udp_pkts_ff, udp_pkts_in;
   logic [COUNT_W-1:0] tcp_bytes_ff, tcp_bytes_in;
   logic [COUNT_W-1:0] udp_bytes_ff, udp_bytes_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic               cmp_last_ff, cmp_last_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // The word in work.
   flow_key_type       key_ff;
   flow_class_type     class_ff;
   logic [LEN_W-1:0]   len_ff;

   // Result register.
   logic [COUNT_W-1:0]     rsp_total_ff, rsp_tcp_pkts_ff, rsp_udp_pkts_ff;
   logic [COUNT_W-1:0]     rsp_tcp_bytes_ff, rsp_udp_bytes_ff;
   logic [FLOWS_W-1:0]     rsp_tcp_flows_ff, rsp_udp_flows_ff;
   logic [ALL_FLOWS_W-1:0] rsp_all_flows_ff;
   logic                   rsp_new_ff, rsp_full_ff;

   // Datapath signals.
   logic             accept;
   logic             load_rsp;
   logic             issue;
   logic             match;
   logic             insert;
   logic             full;
   logic [CNT_W-1:0] used_sel;
   flow_key_type     rd_key;
   logic [KEY_W-1:0] tcp_rd_data, udp_rd_data;
   logic [EXT_W-1:0] tcp_ext, udp_ext, all_ext;
   flow_class_type   req_class;

   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      case (req_if.protocol)
         PROTO_TCP: req_class = CLS_TCP;
         PROTO_UDP: req_class = CLS_UDP;
         default:   req_class = CLS_OTHER;
      endcase
   end

   assign used_sel = (class_ff == CLS_TCP) ? tcp_used_ff : udp_used_ff;
   assign rd_key   = (class_ff == CLS_TCP) ? flow_key_type'(tcp_rd_data)
                                           : flow_key_type'(udp_rd_data);

   // A read is issued while stored entries remain; the data is compared in the next cycle.
   assign issue = (state_ff == ST_SEARCH) && (rd_idx_ff < used_sel);
   assign match = cmp_valid_ff && (rd_key == key_ff);

   // An unseen tuple is appended while room remains, otherwise flagged.
   assign insert = (class_ff != CLS_OTHER) && !hit_ff && (used_sel < TABLE_DEPTH);
   assign full   = (class_ff != CLS_OTHER) && !hit_ff && (used_sel >= TABLE_DEPTH);

   always_comb begin
      state_in     = state_ff;
      tcp_used_in  = tcp_used_ff;
      udp_used_in  = udp_used_ff;
      total_in     = total_ff;
      tcp_pkts_in  = tcp_pkts_ff;
      udp_pkts_in  = udp_pkts_ff;
      tcp_bytes_in = tcp_bytes_ff;
      udp_bytes_in = udp_bytes_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_last_in  = 1'b0;
      hit_in       = hit_ff;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      req_if.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            rd_idx_in    = '0;
            hit_in       = 1'b0;
            if (accept) begin
               // Nothing to search for other protocols or an empty table.
               if ((req_class == CLS_TCP && tcp_used_ff != '0) ||
                   (req_class == CLS_UDP && udp_used_ff != '0)) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SEARCH: begin
            rd_idx_in    = rd_idx_ff + CNT_W'(issue);
            cmp_valid_in = issue;
            cmp_last_in  = issue &&
                           ((CNT_W + 1)'(rd_idx_ff) + 1'b1 == (CNT_W + 1)'(used_sel));
            if (match) begin
               hit_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (cmp_valid_ff && cmp_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               total_in     = sat_add(total_ff, COUNT_W'(1));
               case (class_ff)
                  CLS_TCP: begin
                     tcp_pkts_in  = sat_add(tcp_pkts_ff, COUNT_W'(1));
                     tcp_bytes_in = sat_add(tcp_bytes_ff, COUNT_W'(len_ff));
                     tcp_used_in  = tcp_used_ff + CNT_W'(insert);
                  end
                  CLS_UDP: begin
                     udp_pkts_in  = sat_add(udp_pkts_ff, COUNT_W'(1));
                     udp_bytes_in = sat_add(udp_bytes_ff, COUNT_W'(len_ff));
                     udp_used_in  = udp_used_ff + CNT_W'(insert);
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Flow counts are reported modulo the result field widths.
   assign tcp_ext = EXT_W'(tcp_used_in);
   assign udp_ext = EXT_W'(udp_used_in);
   assign all_ext = tcp_ext + udp_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tcp_used_ff  <= '0;
         udp_used_ff  <= '0;
         total_ff     <= '0;
         tcp_pkts_ff  <= '0;
         udp_pkts_ff  <= '0;
         tcp_bytes_ff <= '0;
         udp_bytes_ff <= '0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_last_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tcp_used_ff  <= tcp_used_in;
         udp_used_ff  <= udp_used_in;
         total_ff     <= total_in;
         tcp_pkts_ff  <= tcp_pkts_in;
         udp_pkts_ff  <= udp_pkts_in;
         tcp_bytes_ff <= tcp_bytes_in;
         udp_bytes_ff <= udp_bytes_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         cmp_last_ff  <= cmp_last_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff   <= '{src:   req_if.source_address,
                       dst:   req_if.destination_address,
                       sport: req_if.source_port,
                       dport: req_if.destination_port};
         class_ff <= req_class;
         len_ff   <= req_if.packet_length;
      end
      if (load_rsp) begin
         rsp_total_ff     <= total_in;
         rsp_tcp_pkts_ff  <= tcp_pkts_in;
         rsp_udp_pkts_ff  <= udp_pkts_in;
         rsp_tcp_bytes_ff <= tcp_bytes_in;
         rsp_udp_bytes_ff <= udp_bytes_in;
         rsp_tcp_flows_ff <= tcp_ext[FLOWS_W-1:0];
         rsp_udp_flows_ff <= udp_ext[FLOWS_W-1:0];
         rsp_all_flows_ff <= all_ext[ALL_FLOWS_W-1:0];
         rsp_new_ff       <= insert;
         rsp_full_ff      <= full;
      end
   end

   // One RAM per protocol. Writes happen only at the end of a word and reads only
   // during the search of a later word, so the two never meet on one entry.
   pfc_ram #(
      .WIDTH (KEY_W),
      .DEPTH (FLOW_ENTRIES)
   ) u_tcp_ram (
      .clock   (clock),
      .wr_en   (load_rsp && insert && class_ff == CLS_TCP),
      .wr_addr (used_sel[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (issue && class_ff == CLS_TCP),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (tcp_rd_data)
   );

   pfc_ram #(
      .WIDTH (KEY_W),
      .DEPTH (FLOW_ENTRIES)
   ) u_udp_ram (
      .clock   (clock),
      .wr_en   (load_rsp && insert && class_ff == CLS_UDP),
      .wr_addr (used_sel[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (issue && class_ff == CLS_UDP),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (udp_rd_data)
   );

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.total_packets  = rsp_total_ff;
   assign rsp_if.tcp_packets    = rsp_tcp_pkts_ff;
   assign rsp_if.udp_packets    = rsp_udp_pkts_ff;
   assign rsp_if.tcp_byte_total = rsp_tcp_bytes_ff;
   assign rsp_if.udp_byte_total = rsp_udp_bytes_ff;
   assign rsp_if.tcp_flow_count = rsp_tcp_flows_ff;
   assign rsp_if.udp_flow_count = rsp_udp_flows_ff;
   assign rsp_if.all_flow_count = rsp_all_flows_ff;
   assign rsp_if.new_flow       = rsp_new_ff;
   assign rsp_if.table_full     = rsp_full_ff;

endmodule

`default_nettype wire

>>> rtl/core/pfc_checker.sv
// Port-level checker for the packet flow counter, bound to the top level.
// Depends on pfc_pkg and the macros in packet_flow_counter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "packet_flow_counter_assert.svh"

module pfc_checker import pfc_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [COUNT_W-1:0]     total_packets,
   input wire logic [COUNT_W-1:0]     tcp_packets,
   input wire logic [COUNT_W-1:0]     udp_packets,
   input wire logic [FLOWS_W-1:0]     tcp_flow_count,
   input wire logic [FLOWS_W-1:0]     udp_flow_count,
   input wire logic [ALL_FLOWS_W-1:0] all_flow_count,
   input wire logic                   new_flow,
   input wire logic                   table_full
);

   // A result waiting for the sink is not withdrawn.
   `PFC_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result withdrawn before it was taken")

   // Only one word is in work, so the input closes right after an acceptance.
   `PFC_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready, "second word accepted while one is in work")

   // A tuple is either inserted or dropped, never both.
   `PFC_ASSERT_NOW(a_flags_apart, clock, reset, rsp_valid, !(new_flow && table_full), "new flow and full table flagged together")

   // The combined flow count is the sum of the per-protocol counts.
   `PFC_ASSERT_NOW(a_flow_sum, clock, reset, rsp_valid, all_flow_count == ALL_FLOWS_W'(tcp_flow_count) + ALL_FLOWS_W'(udp_flow_count), "flow counts do not add up")

   // Protocol packet counters never run ahead of the total.
   `PFC_ASSERT_NOW(a_counts_bounded, clock, reset, rsp_valid, tcp_packets <= total_packets && udp_packets <= total_packets, "protocol count above total")

endmodule

bind packet_flow_counter pfc_checker u_pfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .total_packets  (rsp_if.total_packets),
   .tcp_packets    (rsp_if.tcp_packets),
   .udp_packets    (rsp_if.udp_packets),
   .tcp_flow_count (rsp_if.tcp_flow_count),
   .udp_flow_count (rsp_if.udp_flow_count),
   .all_flow_count (rsp_if.all_flow_count),
   .new_flow       (rsp_if.new_flow),
   .table_full     (rsp_if.table_full)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for packet_flow_counter: header words in, count words out.
// Depends on pfc_pkg, the channel interfaces in pfc_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
   import pfc_pkg::*;

   // The flow tables are built at their default depth.
   localparam int TABLE_DEPTH = 256;
   localparam int TCP_SIDE    = 0;
   localparam int UDP_SIDE    = 1;
   // Worst case per word is a full search plus the longest gap on either side,
   // so the limit leaves several times the slowest legal run.
   localparam int CYCLE_LIMIT = 2000000;

   // One header word as the sender drives it.
   typedef struct {
      logic [PROTO_W-1:0] protocol;
      flow_key_type       key;
      logic [LEN_W-1:0]   length;
   } header_type;

   // One count word as the block should return it.
   typedef struct {
      logic [COUNT_W-1:0]     total_packets;
      logic [COUNT_W-1:0]     tcp_packets;
      logic [COUNT_W-1:0]     udp_packets;
      logic [COUNT_W-1:0]     tcp_byte_total;
      logic [COUNT_W-1:0]     udp_byte_total;
      logic [FLOWS_W-1:0]     tcp_flow_count;
      logic [FLOWS_W-1:0]     udp_flow_count;
      logic [ALL_FLOWS_W-1:0] all_flow_count;
      logic                   new_flow;
      logic                   table_full;
   } count_word_type;

   logic clock;
   logic reset;

   pfc_req_if req_if ();
   pfc_rsp_if rsp_if ();

   packet_flow_counter #(
      .FLOW_ENTRIES(TABLE_DEPTH)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Shadow copy of the block's state, advanced once per accepted header word.
   logic [COUNT_W-1:0] packet_total;
   logic [COUNT_W-1:0] proto_packets [2];
   logic [COUNT_W-1:0] proto_bytes [2];
   flow_key_type       flow_store [2][TABLE_DEPTH];
   int                 flows_used [2];

   // Count words still owed by the block, oldest first.
   count_word_type expected_counts[$];

   int mismatch_count = 0;
   int headers_sent   = 0;
   int flows_inserted = 0;
   int flows_dropped  = 0;
   int flows_matched  = 0;
   int req_quiet      = 0;
   int rsp_quiet      = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Addition that holds at all ones rather than wrapping.
   function automatic logic [COUNT_W-1:0] add_held(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] wide;
      wide = a + b;
      if (wide[COUNT_W])
         return '1;
      return wide[COUNT_W-1:0];
   endfunction

   // True when the tuple already sits in the given protocol's table.
   function automatic bit flow_known(input int side, input flow_key_type key);
      for (int i = 0; i < flows_used[side]; i++) begin
         if (flow_store[side][i] == key)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the shadow state by one header word and returns the count word
   // that the block must produce for it.
   function automatic count_word_type predict_counts(input header_type h);
      count_word_type w;
      int side;
      int flow_sum;
      w.new_flow   = 1'b0;
      w.table_full = 1'b0;
      packet_total = add_held(packet_total, 1);
      if (h.protocol == PROTO_TCP || h.protocol == PROTO_UDP) begin
         side = (h.protocol == PROTO_TCP) ? TCP_SIDE : UDP_SIDE;
         proto_packets[side] = add_held(proto_packets[side], 1);
         proto_bytes[side]   = add_held(proto_bytes[side], {16'd0, h.length});
         if (flow_known(side, h.key)) begin
            flows_matched++;
         end else if (flows_used[side] >= TABLE_DEPTH) begin
            // No room left: the tuple is reported and forgotten.
            w.table_full = 1'b1;
            flows_dropped++;
         end else begin
            flow_store[side][flows_used[side]] = h.key;
            flows_used[side]++;
            w.new_flow = 1'b1;
            flows_inserted++;
         end
      end
      flow_sum = flows_used[TCP_SIDE] + flows_used[UDP_SIDE];
      w.total_packets  = packet_total;
      w.tcp_packets    = proto_packets[TCP_SIDE];
      w.udp_packets    = proto_packets[UDP_SIDE];
      w.tcp_byte_total = proto_bytes[TCP_SIDE];
      w.udp_byte_total = proto_bytes[UDP_SIDE];
      w.tcp_flow_count = flows_used[TCP_SIDE][FLOWS_W-1:0];
      w.udp_flow_count = flows_used[UDP_SIDE][FLOWS_W-1:0];
      w.all_flow_count = flow_sum[ALL_FLOWS_W-1:0];
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Idle cycles before the next word on one side. Now and then a run of
   // back-to-back words is started so that stretches without gaps occur.
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         quiet = $urandom_range(5, 30);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [PROTO_W-1:0] side_protocol(input int side);
      return (side == TCP_SIDE) ? PROTO_TCP : PROTO_UDP;
   endfunction

   function automatic flow_key_type random_key();
      flow_key_type key;
      key.src   = $urandom;
      key.dst   = $urandom;
      key.sport = $urandom_range(0, 65535);
      key.dport = $urandom_range(0, 65535);
      return key;
   endfunction

   // A tuple that differs from the given one in a single bit, so that an
   // inexact compare in any field would show up as a false match.
   function automatic flow_key_type near_miss(input flow_key_type key);
      logic [KEY_W-1:0] bits;
      bits = key;
      bits[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
      return flow_key_type'(bits);
   endfunction

   function automatic header_type make_header(input logic [PROTO_W-1:0] protocol,
                                              input logic [ADDR_W-1:0] src,
                                              input logic [ADDR_W-1:0] dst,
                                              input logic [PORT_W-1:0] sport,
                                              input logic [PORT_W-1:0] dport,
                                              input logic [LEN_W-1:0] length);
      header_type h;
      h.protocol  = protocol;
      h.key.src   = src;
      h.key.dst   = dst;
      h.key.sport = sport;
      h.key.dport = dport;
      h.length    = length;
      return h;
   endfunction

   // A random header word. Most are TCP or UDP; the tuple is either fresh,
   // one already stored, a one-bit neighbour of a stored one, or a tuple
   // borrowed from the other protocol's table.
   function automatic header_type pick_header();
      header_type h;
      int roll;
      int side;
      int other;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         h.protocol = PROTO_TCP;
      end else if (roll < 80) begin
         h.protocol = PROTO_UDP;
      end else begin
         do h.protocol = $urandom_range(0, 255);
         while (h.protocol == PROTO_TCP || h.protocol == PROTO_UDP);
      end
      case ($urandom_range(0, 19))
         0: begin
            h.length = '0;
         end
         1: begin
            h.length = '1;
         end
         default: begin
            h.length = $urandom_range(0, 65535);
         end
      endcase
      side  = (h.protocol == PROTO_UDP) ? UDP_SIDE : TCP_SIDE;
      other = (side == TCP_SIDE) ? UDP_SIDE : TCP_SIDE;
      roll  = $urandom_range(0, 99);
      if (roll < 50 || flows_used[side] == 0) begin
         h.key = random_key();
      end else if (roll < 80) begin
         h.key = flow_store[side][$urandom_range(0, flows_used[side] - 1)];
      end else if (roll < 92) begin
         h.key = near_miss(flow_store[side][$urandom_range(0, flows_used[side] - 1)]);
      end else if (flows_used[other] > 0) begin
         h.key = flow_store[other][$urandom_range(0, flows_used[other] - 1)];
      end else begin
         h.key = random_key();
      end
      return h;
   endfunction

   // Sends one header word and records the count word it must produce.
   // Called and returning at a falling edge; valid is left high so that a
   // following word without a gap goes out back to back.
   task automatic send_header(input header_type h);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.protocol            = h.protocol;
      req_if.source_address      = h.key.src;
      req_if.destination_address = h.key.dst;
      req_if.source_port         = h.key.sport;
      req_if.destination_port    = h.key.dport;
      req_if.packet_length       = h.length;
      req_if.valid               = 1'b1;
      do @(posedge clock);
      while (req_if.ready !== 1'b1);
      expected_counts.push_back(predict_counts(h));
      headers_sent++;
      @(negedge clock);
   endtask

   // Stops sending and waits until every owed count word has come back.
   task automatic wait_for_all_counts();
      req_if.valid = 1'b0;
      while (expected_counts.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, every protocol class, known tuples and tuples that
   // differ only by swapped or neighbouring fields.
   task automatic test_directed_headers();
      send_header(make_header(PROTO_TCP, '0, '0, '0, '0, '0));
      send_header(make_header(PROTO_TCP, '0, '0, '0, '0, '1));
      // The same tuple lives separately in the UDP table.
      send_header(make_header(PROTO_UDP, '0, '0, '0, '0, '1));
      send_header(make_header(PROTO_TCP, '1, '1, '1, '1, '1));
      send_header(make_header(PROTO_UDP, '1, '1, '1, '1, '0));
      // Other protocols move only the total, including near neighbours of
      // the two tracked numbers.
      send_header(make_header(8'd0, '1, '1, '1, '1, '1));
      send_header(make_header(8'd255, '0, '0, '0, '0, '1));
      send_header(make_header(8'd7, '0, '0, '0, '0, 16'd100));
      send_header(make_header(8'd16, '1, '1, '1, '1, 16'd100));
      send_header(make_header(8'h86, '0, '0, '0, '0, 16'd100));
      send_header(make_header(8'h91, '0, '0, '0, '0, 16'd100));
      // Exact compare: a single port differs, then addresses and ports swap.
      send_header(make_header(PROTO_TCP, '0, '0, '0, 16'd1, 16'd60));
      send_header(make_header(PROTO_TCP, 32'h0A000001, 32'hC0A80001, 16'd80, 16'd443, 16'd60));
      send_header(make_header(PROTO_TCP, 32'hC0A80001, 32'h0A000001, 16'd80, 16'd443, 16'd60));
      send_header(make_header(PROTO_TCP, 32'h0A000001, 32'hC0A80001, 16'd443, 16'd80, 16'd60));
      send_header(make_header(PROTO_TCP, 32'h0A000001, 32'hC0A80001, 16'd80, 16'd443, 16'd60));
      // Known UDP tuples with large lengths to build up the byte total.
      send_header(make_header(PROTO_UDP, '1, '1, '1, '1, '1));
      send_header(make_header(PROTO_UDP, '1, '1, '1, '1, '1));
      send_header(make_header(PROTO_UDP, '0, '0, '0, '0, '1));
      wait_for_all_counts();
   endtask

   // Random traffic, sent both while the tables fill and once they are full.
   task automatic test_mixed_traffic(input int words);
      for (int i = 0; i < words; i++)
         send_header(pick_header());
   endtask

   // Fills both tables to the last entry, then offers unseen tuples, a
   // one-bit neighbour of the last entry and the first and last entries.
   task automatic test_table_overflow();
      header_type h;
      for (int side = TCP_SIDE; side <= UDP_SIDE; side++) begin
         while (flows_used[side] < TABLE_DEPTH) begin
            h.protocol = side_protocol(side);
            h.length   = $urandom_range(0, 65535);
            do h.key = random_key();
            while (flow_known(side, h.key));
            send_header(h);
         end
      end
      for (int side = TCP_SIDE; side <= UDP_SIDE; side++) begin
         h.protocol = side_protocol(side);
         h.length   = $urandom_range(0, 65535);
         for (int i = 0; i < 3; i++) begin
            h.key = random_key();
            send_header(h);
         end
         h.key = near_miss(flow_store[side][TABLE_DEPTH - 1]);
         send_header(h);
         h.key = flow_store[side][TABLE_DEPTH - 1];
         send_header(h);
         h.key = flow_store[side][0];
         send_header(h);
      end
      wait_for_all_counts();
   endtask

   // ---------------------------------------------------------------------
   // Count word receiver and checker
   // ---------------------------------------------------------------------

   // Receiver side: stalls for a random number of cycles before each word.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = draw_gap(rsp_quiet);
         if (stall > 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock);
         while (reset || rsp_if.valid !== 1'b1);
         @(negedge clock);
      end
   end

   task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Each accepted count word is compared with the oldest owed one.
   always @(posedge clock) begin
      count_word_type w;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_counts.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: count word expected none, got total_packets %0d",
                     $time, rsp_if.total_packets);
         end else begin
            w = expected_counts.pop_front();
            check_field("total_packets", w.total_packets, rsp_if.total_packets);
            check_field("tcp_packets", w.tcp_packets, rsp_if.tcp_packets);
            check_field("udp_packets", w.udp_packets, rsp_if.udp_packets);
            check_field("tcp_byte_total", w.tcp_byte_total, rsp_if.tcp_byte_total);
            check_field("udp_byte_total", w.udp_byte_total, rsp_if.udp_byte_total);
            check_field("tcp_flow_count", w.tcp_flow_count, rsp_if.tcp_flow_count);
            check_field("udp_flow_count", w.udp_flow_count, rsp_if.udp_flow_count);
            check_field("all_flow_count", w.all_flow_count, rsp_if.all_flow_count);
            check_field("new_flow", w.new_flow, rsp_if.new_flow);
            check_field("table_full", w.table_full, rsp_if.table_full);
         end
      end
   end

   // Guard against a hung handshake.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Run stopped after %0d cycles without completing", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      reset                      = 1'b1;
      req_if.valid               = 1'b0;
      req_if.protocol            = '0;
      req_if.source_address      = '0;
      req_if.destination_address = '0;
      req_if.source_port         = '0;
      req_if.destination_port    = '0;
      req_if.packet_length       = '0;
      packet_total               = '0;
      for (int side = TCP_SIDE; side <= UDP_SIDE; side++) begin
         proto_packets[side] = '0;
         proto_bytes[side]   = '0;
         flows_used[side]    = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_headers();
      test_mixed_traffic(550);
      // The sender holds off here until the block has answered everything.
      wait_for_all_counts();
      test_table_overflow();
      test_mixed_traffic(250);

      wait_for_all_counts();
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      mismatch_count += expected_counts.size();

      $display("Sent %0d header words: %0d flows stored, %0d repeats matched, %0d dropped",
               headers_sent, flows_inserted, flows_matched, flows_dropped);
      $display("Tables ended with %0d TCP and %0d UDP tuples of %0d each",
               flows_used[TCP_SIDE], flows_used[UDP_SIDE], TABLE_DEPTH);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pfc_pkg.sv
rtl/core/pfc_if.sv
rtl/core/pfc_ram.sv
rtl/core/packet_flow_counter.sv
rtl/core/pfc_checker.sv
tb/testbench.sv
